// ===== hdl/bop_pkg.sv =====
`default_nettype none
package bop_pkg;
  localparam int MaxSteps   = 1024;
  localparam int PriceW     = 48;
  localparam int FactorW    = 32;
  localparam int ProbW      = 31;
  localparam int StepW      = 11;
  localparam int AddrW      = $clog2(MaxSteps + 1);
  localparam int FactorShift = 30;
  localparam int MulSplit   = 16;
  localparam logic [PriceW-1:0] PriceMax = {PriceW{1'b1}};
  localparam logic [ProbW-1:0] FactorOne = ProbW'(1) << FactorShift;

  localparam logic [2:0] RegUp     = 3'd0;
  localparam logic [2:0] RegRatio  = 3'd1;
  localparam logic [2:0] RegInvUp  = 3'd2;
  localparam logic [2:0] RegProb   = 3'd3;
  localparam logic [2:0] RegDisc   = 3'd4;
  localparam logic [2:0] RegSteps  = 3'd5;
  localparam logic [2:0] RegPut    = 3'd6;
  localparam logic [2:0] RegAmer   = 3'd7;

  // merge partial products of a*b: hb = a[47:16]*b, lb = a[15:0]*b
  // floor(a*b/2^30) saturated; returns {sat, value}
  function automatic logic [PriceW:0] mul_factor(input logic [2*FactorW-1:0] hb,
                                                 input logic [PriceW-1:0] lb);
    logic [2*FactorW:0] s;
    s = {1'b0, hb} + {{(FactorW+1){1'b0}}, lb[PriceW-1:MulSplit]};
    if (s[2*FactorW:PriceW+FactorShift-MulSplit] != '0) begin
      return {1'b1, PriceMax};
    end
    return {1'b0, s[PriceW+FactorShift-MulSplit-1:FactorShift-MulSplit]};
  endfunction

  function automatic logic [PriceW-1:0] payoff(input logic put,
                                               input logic [PriceW-1:0] pr,
                                               input logic [PriceW-1:0] k);
    if (put) return (k > pr) ? k - pr : '0;
    return (pr > k) ? pr - k : '0;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/binomial_option_pricer.sv =====
`default_nettype none
// Channel | Direction | Handshake           | Payload
// in_     | slave     | in_tvalid/in_tready | tdata: spot[47:0], strike[95:48]
// out_    | master    | out_tvalid/tready   | tdata: option_value[47:0]; tuser: overflow
// cfg_    | slave     | cfg_valid/cfg_ready | cfg_index[2:0], cfg_data[31:0]
// Per item: spot powers, then the maturity row, then n(n+1)/2 node updates, then
// the result load. Each product is formed as a high part and then a low part and merge
// on one shared 32x32 multiplier; memory reads are registered.
// Reset (rst_n low, synchronous) clears control and config; memories hold no reset.
// One item at a time; a finished result waits in the output register and holds off
// the input until its transfer.
module binomial_option_pricer
  import bop_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // spot_price, strike_price
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // option_value
  output logic             out_tuser,  // overflow
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_POW = 8'b00000010, S_ROW = 8'b00000100,
    S_RD   = 8'b00001000, S_N1  = 8'b00010000, S_N2  = 8'b00100000,
    S_N3   = 8'b01000000, S_DONE = 8'b10000000
  } state_t;

  state_t state_r;
  logic [FactorW-1:0] up_r, ratio_r, inv_r;
  logic [ProbW-1:0]   prob_r, disc_r;
  logic [StepW-1:0]   steps_r;
  logic               put_r, amer_r;

  logic [PriceW-1:0] strike_r, top_r, acc_r, vj_r, pj_r, res_r;
  logic [StepW-1:0]  n_r, k_r, i_r, j_r;
  logic              sat_r, oflow_r, outv_r;
  logic [1:0]        sub_r;
  logic              mph_r;      // multiply phase: 0 high part, 1 low part and merge
  logic [2*FactorW-1:0] hi_r;

  logic [PriceW-1:0] price_mem [MaxSteps+1];
  logic [PriceW-1:0] value_mem [MaxSteps+1];
  logic [PriceW-1:0] prd_r, vrd_r;
  logic [AddrW-1:0]  raddr;

  logic [ProbW-1:0]   p_cl, q_cl;
  logic [StepW-1:0]   n_cl;
  logic [PriceW-1:0]  mul_a;
  logic [FactorW-1:0] mul_b;
  logic               mul_go;
  logic [FactorW-1:0] mul_part;
  logic [2*FactorW-1:0] pp;
  logic [PriceW:0]    mul_y;
  logic [PriceW:0]    sum;

  assign p_cl = (prob_r > FactorOne) ? FactorOne : prob_r;
  assign q_cl = FactorOne - p_cl;
  assign n_cl = (steps_r > StepW'(MaxSteps)) ? StepW'(MaxSteps) : steps_r;
  assign in_tready = (state_r == S_IDLE) && !(outv_r && !out_tready);
  assign cfg_ready = 1'b1;
  assign out_tvalid = outv_r;
  assign out_tdata = res_r;
  assign out_tuser = oflow_r;
  // split product: high 32 bits of a first, then low 16 bits and merge
  assign mul_part = mph_r ? {16'd0, mul_a[MulSplit-1:0]} : mul_a[PriceW-1:MulSplit];
  assign pp = {{FactorW{1'b0}}, mul_part} * {{FactorW{1'b0}}, mul_b};
  assign mul_y = mul_factor(hi_r, pp[PriceW-1:0]);
  assign sum = {1'b0, acc_r} + {1'b0, mul_y[PriceW-1:0]};

  // shared multiplier operand select
  always_comb begin
    mul_a = top_r;
    mul_b = up_r;
    raddr = j_r[AddrW-1:0];
    mul_go = 1'b0;
    unique case (state_r)
      S_POW: mul_go = (k_r != n_r);
      S_ROW: begin mul_a = top_r; mul_b = ratio_r; mul_go = (j_r != n_r); end
      S_N1: begin mul_a = prd_r; mul_b = inv_r; mul_go = (sub_r == 2'd0); end
      S_N2: begin
        mul_a = vj_r; mul_b = {1'b0, p_cl}; raddr = AddrW'(j_r + 1'b1); mul_go = 1'b1;
      end
      S_N3: begin
        mul_a = (sub_r == 2'd0) ? vrd_r : acc_r;
        mul_b = (sub_r == 2'd0) ? {1'b0, q_cl} : {1'b0, disc_r};
        // keep V(j+1) on the read port for both multiply phases
        if (sub_r == 2'd0) raddr = AddrW'(j_r + 1'b1);
        mul_go = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prd_r <= price_mem[raddr];
    vrd_r <= value_mem[raddr];
    hi_r <= pp;
    if (state_r == S_ROW) begin
      price_mem[j_r[AddrW-1:0]] <= top_r;
      value_mem[j_r[AddrW-1:0]] <= payoff(put_r, top_r, strike_r);
    end else if (state_r == S_N1 && sub_r == 2'd1) begin
      price_mem[j_r[AddrW-1:0]] <= pj_r;
    end else if (state_r == S_N3 && sub_r == 2'd1 && mph_r) begin
      value_mem[j_r[AddrW-1:0]] <=
        (amer_r && payoff(put_r, pj_r, strike_r) > mul_y[PriceW-1:0])
        ? payoff(put_r, pj_r, strike_r) : mul_y[PriceW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; outv_r <= 1'b0; sat_r <= 1'b0; mph_r <= 1'b0;
      up_r <= 32'h4000_0000; ratio_r <= 32'h4000_0000; inv_r <= 32'h4000_0000;
      prob_r <= 31'h2000_0000; disc_r <= 31'h4000_0000;
      steps_r <= 11'd1000; put_r <= 1'b1; amer_r <= 1'b1;
    end else begin
      mph_r <= mul_go && !mph_r;
      if (outv_r && out_tready) outv_r <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          RegUp:    up_r <= cfg_data;
          RegRatio: ratio_r <= cfg_data;
          RegInvUp: inv_r <= cfg_data;
          RegProb:  prob_r <= cfg_data[ProbW-1:0];
          RegDisc:  disc_r <= cfg_data[ProbW-1:0];
          RegSteps: steps_r <= cfg_data[StepW-1:0];
          RegPut:   put_r <= cfg_data[0];
          RegAmer:  amer_r <= cfg_data[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          strike_r <= in_tdata[95:48];
          top_r <= in_tdata[47:0]; n_r <= n_cl; k_r <= '0; j_r <= '0;
          sat_r <= 1'b0; state_r <= S_POW;
        end
        S_POW: if (k_r == n_r) state_r <= S_ROW;
          else if (mph_r) begin
            top_r <= mul_y[PriceW-1:0]; sat_r <= sat_r | mul_y[PriceW];
            k_r <= k_r + 1'b1;
          end
        S_ROW: begin
          if (j_r == n_r) begin
            i_r <= n_r; j_r <= '0; sub_r <= 2'd0;
            state_r <= (n_r == '0) ? S_DONE : S_RD;
          end else if (mph_r) begin
            top_r <= mul_y[PriceW-1:0]; sat_r <= sat_r | mul_y[PriceW];
            j_r <= j_r + 1'b1;
          end
        end
        S_RD: begin sub_r <= 2'd0; state_r <= S_N1; end
        S_N1: begin
          if (sub_r == 2'd0) begin
            if (mph_r) begin
              pj_r <= mul_y[PriceW-1:0]; sat_r <= sat_r | mul_y[PriceW];
              vj_r <= vrd_r; sub_r <= 2'd1;
            end
          end else state_r <= S_N2;
        end
        S_N2: if (mph_r) begin
          acc_r <= mul_y[PriceW-1:0]; sat_r <= sat_r | mul_y[PriceW];
          sub_r <= 2'd0; state_r <= S_N3;
        end
        S_N3: if (mph_r) begin
          if (sub_r == 2'd0) begin
            sat_r <= sat_r | mul_y[PriceW] | sum[PriceW];
            acc_r <= sum[PriceW] ? PriceMax : sum[PriceW-1:0];
            sub_r <= 2'd1;
          end else begin
            sat_r <= sat_r | mul_y[PriceW];
            sub_r <= 2'd0;
            if (j_r + 1'b1 == i_r) begin
              j_r <= '0; i_r <= i_r - 1'b1;
              state_r <= (i_r == StepW'(1)) ? S_DONE : S_RD;
            end else begin
              j_r <= j_r + 1'b1; state_r <= S_RD;
            end
          end
        end
        // first cycle lets the read of the freshly written root settle
        S_DONE: if (sub_r == 2'd0) sub_r <= 2'd1;
          else if (!outv_r) begin
            res_r <= vrd_r; oflow_r <= sat_r; outv_r <= 1'b1; state_r <= S_IDLE;
          end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import bop_pkg::*;

  localparam int IdleLimit = 30000000;  // covers the longest item (n = 1024)

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;            // spot_price[47:0], strike_price[95:48]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;                // option_value[47:0]
  logic        out_tuser;                // overflow
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #10 clk = ~clk;

  binomial_option_pricer DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // shadow copy of the register file, updated on each cfg transfer
  logic [31:0] up_q    = 32'h4000_0000;
  logic [31:0] ratio_q = 32'h4000_0000;
  logic [31:0] invup_q = 32'h4000_0000;
  logic [30:0] prob_q  = 31'h2000_0000;
  logic [30:0] disc_q  = 31'h4000_0000;
  logic [10:0] steps_q = 11'd1000;
  logic        put_q   = 1'b1;
  logic        amer_q  = 1'b1;

  logic [95:0] pending_items[$];        // spot/strike pairs not yet transferred
  logic [48:0] expected_values[$];      // {overflow, option_value}
  int          errors = 0;
  int          items_sent = 0;
  int          values_seen = 0;
  int          ovf_seen = 0;
  int          phases = 0;

  // --------------------------------------------------------------------------
  // Lattice valuation, computed independently of the RTL
  // --------------------------------------------------------------------------
  logic [47:0] lat_price[0:MaxSteps];
  logic [47:0] lat_value[0:MaxSteps];
  logic        lat_sat;

  function logic [47:0] fx_scale(input logic [47:0] a, input logic [31:0] f);
    logic [79:0] prod;
    prod = {32'd0, a} * {48'd0, f};
    prod = prod >> FactorShift;
    if (prod[79:48] != 0) begin
      lat_sat = 1'b1;
      return PriceMax;
    end
    return prod[47:0];
  endfunction

  function logic [47:0] exercise(input logic [47:0] pr, input logic [47:0] k);
    if (put_q) return (k > pr) ? k - pr : 48'd0;
    return (pr > k) ? pr - k : 48'd0;
  endfunction

  function logic [48:0] lattice_value(input logic [47:0] spot, input logic [47:0] strike);
    logic [31:0] p, q;
    logic [48:0] sum;
    logic [47:0] cont, ex;
    int n;
    lat_sat = 1'b0;
    // probability above one clamps to 1.0, step count clamps to MaxSteps
    p = (prob_q > 31'(1 << FactorShift)) ? 32'(1 << FactorShift) : {1'b0, prob_q};
    q = 32'(1 << FactorShift) - p;
    n = (steps_q > MaxSteps) ? MaxSteps : int'(steps_q);
    lat_price[0] = spot;
    for (int k = 0; k < n; k++) lat_price[0] = fx_scale(lat_price[0], up_q);
    for (int j = 1; j <= n; j++) lat_price[j] = fx_scale(lat_price[j-1], ratio_q);
    for (int j = 0; j <= n; j++) lat_value[j] = exercise(lat_price[j], strike);
    for (int i = n; i > 0; i--) begin
      for (int j = 0; j < i; j++) begin
        lat_price[j] = fx_scale(lat_price[j], invup_q);
        sum = {1'b0, fx_scale(lat_value[j], p)} + {1'b0, fx_scale(lat_value[j+1], q)};
        if (sum[48]) begin
          lat_sat = 1'b1;
          sum = {1'b0, PriceMax};
        end
        cont = fx_scale(sum[47:0], {1'b0, disc_q});
        if (amer_q) begin
          ex = exercise(lat_price[j], strike);
          if (ex > cont) cont = ex;
        end
        lat_value[j] = cont;
      end
    end
    return {lat_sat, lat_value[0]};
  endfunction

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: predicts the result at the moment of the transfer
  // --------------------------------------------------------------------------
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_values.push_back(lattice_value(in_tdata[47:0], in_tdata[95:48]));
        void'(pending_items.pop_front());
        items_sent++;
        send_gap = gap_len();
      end
      if (in_tvalid && !in_tready) begin
        // hold the offer until it is taken
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_items[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: random stalls plus one long hold-off early in the run,
  // so the output register fills and the block backs up its input
  // --------------------------------------------------------------------------
  int  recv_stall = 0;
  int  long_hold = 0;
  bit  hold_done = 1'b0;
  logic [48:0] want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        values_seen++;
        if (out_tuser) ovf_seen++;
        if (expected_values.size() == 0) begin
          $display("%0t: unexpected result value=%h ovf=%b", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          want = expected_values.pop_front();
          if (out_tdata !== want[47:0]) begin
            $display("%0t: option_value expected %h actual %h", $time, want[47:0], out_tdata);
            errors++;
          end
          if (out_tuser !== want[48]) begin
            $display("%0t: overflow expected %b actual %b", $time, want[48], out_tuser);
            errors++;
          end
        end
        if (values_seen == 3 && !hold_done) begin
          long_hold = 400;
          hold_done = 1'b1;
        end else begin
          recv_stall = gap_len();
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: cycles without any transfer
  // --------------------------------------------------------------------------
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IdleLimit) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Phase control
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegUp:    up_q    = val;
      RegRatio: ratio_q = val;
      RegInvUp: invup_q = val;
      RegProb:  prob_q  = val[30:0];
      RegDisc:  disc_q  = val[30:0];
      RegSteps: steps_q = val[10:0];
      RegPut:   put_q   = val[0];
      RegAmer:  amer_q  = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] up, input logic [31:0] ratio,
                           input logic [31:0] invup, input logic [31:0] prob,
                           input logic [31:0] disc, input logic [31:0] steps,
                           input logic put, input logic amer);
    // sender stays quiet until the block has delivered everything
    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_values.size() != 0);
    repeat (8) @(negedge clk);
    reg_write(RegUp, up);
    reg_write(RegRatio, ratio);
    reg_write(RegInvUp, invup);
    reg_write(RegProb, prob);
    reg_write(RegDisc, disc);
    reg_write(RegSteps, steps);
    reg_write(RegPut, {31'd0, put});
    reg_write(RegAmer, {31'd0, amer});
    @(negedge clk);
    phases++;
  endtask

  task automatic queue_item(input logic [47:0] spot, input logic [47:0] strike);
    pending_items.push_back({strike, spot});
  endtask

  function automatic logic [47:0] rand_price();
    logic [47:0] v;
    case ($urandom_range(0, 3))
      0: v = {$urandom(), $urandom()};
      1: v = 48'($urandom_range(1, 300)) << 32 | 48'($urandom());
      2: v = 48'($urandom()) << $urandom_range(0, 16);
      default: v = PriceMax - 48'($urandom());
    endcase
    return v;
  endfunction

  function automatic logic [31:0] near_one(input int spread);
    return 32'h4000_0000 + 32'($urandom_range(0, 2 * spread)) - 32'(spread);
  endfunction

  logic [47:0] s, k;
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // small lattice, American put, field extremes and at/in/out of the money
    configure(32'h4010_0000, 32'h3FE0_0000, 32'h3FF0_0400, 32'h2000_0000,
              32'h3FF0_0000, 32'd3, 1'b1, 1'b1);
    queue_item('0, '0);
    queue_item(PriceMax, PriceMax);
    queue_item(PriceMax, '0);
    queue_item('0, PriceMax);
    queue_item(48'd100 << 32, 48'd110 << 32);
    queue_item(48'd110 << 32, 48'd100 << 32);
    queue_item(48'h0000_5555_AAAA, 48'hAAAA_5555_0000);

    // zero steps: root is the payoff at spot; probability/discount above one
    configure(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'd0, 1'b0, 1'b0);
    queue_item(48'd50 << 32, 48'd40 << 32);
    queue_item(48'd40 << 32, 48'd50 << 32);
    queue_item(PriceMax, 48'd1);
    queue_item(48'h1234_5678_9ABC, 48'h0);

    // saturating factors: overflow must be flagged
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
              32'h0, 32'd5, 1'b0, 1'b1);
    queue_item(PriceMax, 48'd1 << 32);
    queue_item(48'd100 << 32, 48'd90 << 32);
    queue_item(48'd1, 48'd0);

    // probability exactly one, one step, unit discount
    configure(32'h4800_0000, 32'h3000_0000, 32'h3800_0000, 32'h4000_0000,
              32'h4000_0000, 32'd1, 1'b1, 1'b0);
    queue_item(48'd100 << 32, 48'd100 << 32);
    queue_item(48'd80 << 32, 48'd100 << 32);
    queue_item(PriceMax, PriceMax - 48'd7);

    // step count beyond the maximum clamps to 1024: one deep lattice
    configure(near_one(1 << 14), near_one(1 << 14), near_one(1 << 14),
              32'h2000_0000, 32'h3FFF_FF00, 32'd2047, 1'b1, 1'b1);
    queue_item(48'd100 << 32, 48'd105 << 32);

    // random phases with mostly shallow lattices
    for (int ph = 0; ph < 9; ph++) begin
      if (ph % 3 == 2)
        configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom_range(0, 6), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      else
        configure(near_one(1 << 24), near_one(1 << 24), near_one(1 << 24),
                  $urandom_range(0, 32'h4000_0000), $urandom_range(32'h3800_0000, 32'h4000_0000),
                  $urandom_range(1, 8), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      for (int it = 0; it < 11; it++) begin
        s = rand_price();
        k = ($urandom_range(0, 2) == 0) ? rand_price() : s + 48'($urandom()) - 48'($urandom());
        queue_item(s, k);
      end
    end

    do @(negedge clk);
    while (pending_items.size() != 0 || in_tvalid || expected_values.size() != 0);
    repeat (20) @(negedge clk);

    $display("Run covered %0d config phases, %0d items, %0d results (%0d with overflow).",
             phases, items_sent, values_seen, ovf_seen);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
